>>> rtl/npmt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npmt_pkg: shared types and constants of the napt port table
// sizes of the slot store, field widths, register indexes and reset values
// ----------------------------------------------------------------------------
package npmt_pkg;

	localparam int unsigned SLOTS   = 1024;
	localparam int unsigned SLOT_W  = $clog2(SLOTS);
	localparam int unsigned CNT_W   = SLOT_W + 1;
	localparam int unsigned PORT_W  = 16;
	localparam int unsigned IP_W    = 32;
	localparam int unsigned TICK_W  = 64;
	localparam int unsigned CFG_IDX_W = 1;

	localparam logic [PORT_W-1:0] PORT_FIRST_RST = 16'd1024;
	localparam logic [PORT_W-1:0] PORT_LAST_RST  = 16'd2047;

	localparam logic [CFG_IDX_W-1:0] CFG_PORT_FIRST = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_PORT_LAST  = 1'b1;

	typedef struct packed {
		logic              active;
		logic [IP_W-1:0]   ip;
		logic [PORT_W-1:0] port;
		logic [TICK_W-1:0] tick;
	} slot_t;

endpackage

>>> rtl/npmt_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npmt_if: request and response channels of the napt port table
// valid/ready handshake with the payload carried alongside
// ----------------------------------------------------------------------------
interface npmt_req_if;
	logic                           valid;
	logic                           ready;
	logic                           mode;
	logic [npmt_pkg::IP_W-1:0]      internal_ip;
	logic [npmt_pkg::PORT_W-1:0]    internal_port;
	logic [npmt_pkg::PORT_W-1:0]    external_port;
	logic [npmt_pkg::TICK_W-1:0]    now_tick;

	modport source (output valid, mode, internal_ip, internal_port, external_port, now_tick,
		input ready);
	modport sink (input valid, mode, internal_ip, internal_port, external_port, now_tick,
		output ready);
endinterface

interface npmt_rsp_if;
	logic                           valid;
	logic                           ready;
	logic                           found;
	logic [npmt_pkg::PORT_W-1:0]    mapped_port;
	logic [npmt_pkg::IP_W-1:0]      mapped_ip;

	modport source (output valid, found, mapped_port, mapped_ip, input ready);
	modport sink (input valid, found, mapped_port, mapped_ip, output ready);
endinterface

>>> rtl/nat_port_mapping_table_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nat_port_mapping_table_top: napt port allocation table
// one slot per external port, searched by a sequencer over a slot memory
// ----------------------------------------------------------------------------
// Usage: req carries one word (mode, internal ip/port, external port, tick),
// rsp returns one word (found, mapped port, mapped ip) per request. Port
// range registers are written through cfg_we/cfg_index/cfg_data; the user
// must write them only while idle, as the block itself does not enforce it.
// After reset the slot memory is cleared one slot a cycle, with req.ready
// low until every slot is clear. Steps, with n the slot count of the range:
//   empty range or incoming port out of range: answered straight from the accept, no slot read
//   incoming mode: one slot read, then a check and the response
//   outgoing mode: one lookup pass over the n slots of the range, one read a cycle
//   full table: lookup pass, midpoint, eviction pass, claim
// The slot memory has one read and one write port; its reads pace the passes.
// One request is handled at a time; the next is taken once the response
// word has been taken. A stalled rsp holds its word and keeps req.ready low.
// ----------------------------------------------------------------------------
module nat_port_mapping_table_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [npmt_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [npmt_pkg::PORT_W-1:0]         cfg_data,
	npmt_req_if.sink                            req,
	npmt_rsp_if.source                          rsp
);

	localparam int unsigned SW = npmt_pkg::SLOT_W;
	localparam int unsigned CW = npmt_pkg::CNT_W;
	localparam int unsigned PW = npmt_pkg::PORT_W;
	localparam int unsigned TW = npmt_pkg::TICK_W;

	typedef enum logic [3:0] {
		ST_CLR, ST_IDLE, ST_IN_RD, ST_IN_CHK, ST_LOOK, ST_DECIDE,
		ST_MID1, ST_MID2, ST_EVICT, ST_FIN
	} state_t;

	state_t state_q;

	logic [PW-1:0] port_first_q, port_last_q;
	logic [SW-1:0] ptr_q, start_q, sidx_q;
	logic [CW-1:0] n_q, ci_q;
	logic [SW-1:0] di_q;
	logic          dv_q;
	logic [npmt_pkg::IP_W-1:0] ip_q;
	logic [PW-1:0] port_q;
	logic [TW-1:0] now_q, tmin_q, tmax_q, diff_q, mid_q;
	logic          mt_q, fa_q, fb_q;
	logic [SW-1:0] ms_q, fas_q, fbs_q;

	logic          rsp_valid_q, rsp_found_q;
	logic [PW-1:0] rsp_port_q;
	logic [npmt_pkg::IP_W-1:0] rsp_ip_q;

	npmt_pkg::slot_t mem [npmt_pkg::SLOTS];
	npmt_pkg::slot_t rdata_q, wd;
	logic            we;
	logic [SW-1:0]   wa, raddr, cs;

	// slot count and start point from the port range
	logic [PW:0]   span;
	logic [CW-1:0] n_new;
	logic [SW-1:0] start_new;
	logic [PW-1:0] eoff;
	logic          in_ok, accept, pass_end;
	logic [CW-1:0] ptr_nxt;

	assign span = {1'b0, port_last_q} - {1'b0, port_first_q} + (PW+1)'(1);
	always_comb begin
		if (port_last_q < port_first_q) begin
			n_new = '0;
		end else if (span > (PW+1)'(npmt_pkg::SLOTS)) begin
			n_new = CW'(npmt_pkg::SLOTS);
		end else begin
			n_new = span[CW-1:0];
		end
	end
	assign start_new = ({1'b0, ptr_q} < n_new) ? ptr_q : '0;
	assign eoff = req.external_port - port_first_q;
	assign in_ok = (req.external_port >= port_first_q) && (req.external_port <= port_last_q)
		&& ({{(PW-CW){1'b0}}, n_new} > eoff);

	assign req.ready = (state_q == ST_IDLE) && !rsp_valid_q;
	assign accept = req.valid && req.ready;
	assign pass_end = (ci_q == n_q) && !dv_q;

	assign rsp.valid = rsp_valid_q;
	assign rsp.found = rsp_found_q;
	assign rsp.mapped_port = rsp_port_q;
	assign rsp.mapped_ip = rsp_ip_q;

	// claim target: matching slot or free slot from the lookup pass, or an evicted slot
	always_comb begin
		if (state_q == ST_FIN) begin
			cs = fa_q ? fas_q : fbs_q;
		end else begin
			cs = mt_q ? ms_q : (fa_q ? fas_q : fbs_q);
		end
	end
	assign ptr_nxt = {1'b0, cs} + CW'(1);

	assign raddr = (state_q == ST_IN_RD) ? sidx_q : ci_q[SW-1:0];

	always_comb begin
		we = 1'b0;
		wa = cs;
		wd = '{active: 1'b1, ip: ip_q, port: port_q, tick: now_q};
		unique case (state_q)
			ST_CLR: begin
				we = 1'b1;
				wa = ci_q[SW-1:0];
				wd = '0;
			end
			ST_IN_CHK: begin
				we = rdata_q.active;
				wa = sidx_q;
				wd = '{active: 1'b1, ip: rdata_q.ip, port: rdata_q.port, tick: now_q};
			end
			ST_DECIDE: begin
				we = mt_q || fa_q || fb_q;
			end
			ST_EVICT: begin
				we = dv_q && (rdata_q.tick <= mid_q);
				wa = di_q;
				wd = '{active: 1'b0, ip: rdata_q.ip, port: rdata_q.port, tick: rdata_q.tick};
			end
			ST_FIN: begin
				we = fa_q || fb_q;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
		if (we) begin
			mem[wa] <= wd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLR;
			port_first_q <= npmt_pkg::PORT_FIRST_RST;
			port_last_q  <= npmt_pkg::PORT_LAST_RST;
			ptr_q        <= '0;
			ci_q         <= '0;
			dv_q         <= 1'b0;
			mt_q         <= 1'b0;
			fa_q         <= 1'b0;
			fb_q         <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					npmt_pkg::CFG_PORT_FIRST: port_first_q <= cfg_data;
					npmt_pkg::CFG_PORT_LAST:  port_last_q  <= cfg_data;
					default: ;
				endcase
			end
			if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_CLR: begin
					if (ci_q == CW'(npmt_pkg::SLOTS - 1)) begin
						ci_q    <= '0;
						state_q <= ST_IDLE;
					end else begin
						ci_q <= ci_q + CW'(1);
					end
				end
				ST_IDLE: begin
					if (accept) begin
						ip_q    <= req.internal_ip;
						port_q  <= req.internal_port;
						now_q   <= req.now_tick;
						n_q     <= n_new;
						start_q <= start_new;
						sidx_q  <= eoff[SW-1:0];
						ci_q    <= '0;
						dv_q    <= 1'b0;
						mt_q    <= 1'b0;
						fa_q    <= 1'b0;
						fb_q    <= 1'b0;
						if (n_new == '0 || (req.mode && !in_ok)) begin
							rsp_valid_q <= 1'b1;
							rsp_found_q <= 1'b0;
							rsp_port_q  <= '0;
							rsp_ip_q    <= '0;
						end else if (req.mode) begin
							state_q <= ST_IN_RD;
						end else begin
							state_q <= ST_LOOK;
						end
					end
				end
				ST_IN_RD: begin
					state_q <= ST_IN_CHK;
				end
				ST_IN_CHK: begin
					rsp_valid_q <= 1'b1;
					rsp_found_q <= rdata_q.active;
					rsp_port_q  <= rdata_q.active ? rdata_q.port : '0;
					rsp_ip_q    <= rdata_q.active ? rdata_q.ip : '0;
					state_q     <= ST_IDLE;
				end
				ST_LOOK, ST_EVICT: begin
					if (ci_q < n_q) begin
						ci_q <= ci_q + CW'(1);
						di_q <= ci_q[SW-1:0];
						dv_q <= 1'b1;
					end else begin
						dv_q <= 1'b0;
					end
					if (dv_q && state_q == ST_LOOK) begin
						if (rdata_q.active && rdata_q.ip == ip_q && rdata_q.port == port_q
							&& !mt_q) begin
							mt_q <= 1'b1;
							ms_q <= di_q;
						end
						if (!rdata_q.active && di_q >= start_q && !fa_q) begin
							fa_q  <= 1'b1;
							fas_q <= di_q;
						end
						if (!rdata_q.active && !fb_q) begin
							fb_q  <= 1'b1;
							fbs_q <= di_q;
						end
						if (di_q == '0) begin
							tmin_q <= rdata_q.tick;
							tmax_q <= rdata_q.tick;
						end else begin
							if (rdata_q.tick < tmin_q) tmin_q <= rdata_q.tick;
							if (rdata_q.tick > tmax_q) tmax_q <= rdata_q.tick;
						end
					end
					// evicted slots after the start point come first, then the wrap part
					if (dv_q && state_q == ST_EVICT && rdata_q.tick <= mid_q) begin
						if (di_q > start_q && !fa_q) begin
							fa_q  <= 1'b1;
							fas_q <= di_q;
						end
						if (di_q < start_q && !fb_q) begin
							fb_q  <= 1'b1;
							fbs_q <= di_q;
						end
					end
					if (pass_end) begin
						state_q <= (state_q == ST_LOOK) ? ST_DECIDE : ST_FIN;
					end
				end
				ST_DECIDE: begin
					if (mt_q || fa_q || fb_q) begin
						rsp_valid_q <= 1'b1;
						rsp_found_q <= 1'b1;
						rsp_port_q  <= port_first_q + PW'(cs);
						rsp_ip_q    <= '0;
						if (!mt_q) begin
							ptr_q <= (ptr_nxt >= n_q) ? '0 : ptr_nxt[SW-1:0];
						end
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_MID1;
					end
				end
				ST_MID1: begin
					diff_q  <= tmax_q - tmin_q;
					state_q <= ST_MID2;
				end
				ST_MID2: begin
					mid_q   <= tmin_q + (diff_q >> 1);
					ci_q    <= '0;
					dv_q    <= 1'b0;
					state_q <= ST_EVICT;
				end
				ST_FIN: begin
					rsp_valid_q <= 1'b1;
					rsp_found_q <= fa_q || fb_q;
					rsp_port_q  <= (fa_q || fb_q) ? port_first_q + PW'(cs) : '0;
					rsp_ip_q    <= '0;
					if (fa_q || fb_q) begin
						ptr_q <= (ptr_nxt >= n_q) ? '0 : ptr_nxt[SW-1:0];
					end
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_ready_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		req.ready |-> !rsp.valid)
		else $error("request taken while a response word is pending");

	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLR) |-> !req.ready)
		else $error("request taken during memory clear");

	a_look_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOOK) |-> !we)
		else $error("slot memory written during lookup pass");

	a_accept_resp: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && n_new == '0) |=> rsp.valid && !rsp.found)
		else $error("empty range did not answer with a failure");

endmodule
